@@ hw/rtl/ordered_list_insert_remove_core_macros.svh @@
// assertion helpers for the core rtl file
`ifndef ORDERED_LIST_INSERT_REMOVE_CORE_MACROS_SVH
`define ORDERED_LIST_INSERT_REMOVE_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define OLIR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olir same-cycle check failed");

// next-cycle implication, quiet during reset
`define OLIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olir next-cycle check failed");

`endif

@@ hw/rtl/olir_pkg.sv @@
`timescale 1ns / 1ps

package olir_pkg;

   // list geometry
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);

   // field widths
   localparam int OP_W  = 2;
   localparam int VAL_W = 32;
   localparam int POS_W = 5;
   localparam int ST_W  = 2;
   localparam int CNT_W = 5;

   // operation codes
   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_POP    = 2'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

   // status codes
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

   // command broadcast to every cell
   typedef struct packed {
      logic                    insert;
      logic                    remove;
      logic [IDX_W-1:0]        at;
      logic signed [VAL_W-1:0] value;
   } cell_cmd_type;

endpackage

@@ hw/rtl/olir_if.sv @@
`timescale 1ns / 1ps

// request channel
interface olir_req_if;
   logic                              valid;
   logic                              ready;
   logic [olir_pkg::OP_W-1:0]         op;
   logic signed [olir_pkg::VAL_W-1:0] value;
   logic [olir_pkg::POS_W-1:0]        position;

   modport source (output valid, op, value, position, input ready);
   modport sink (input valid, op, value, position, output ready);
endinterface

// response channel
interface olir_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [olir_pkg::VAL_W-1:0] popped_value;
   logic [olir_pkg::ST_W-1:0]         status;
   logic [olir_pkg::CNT_W-1:0]        count;

   modport source (output valid, popped_value, status, count, input ready);
   modport sink (input valid, popped_value, status, count, output ready);
endinterface

@@ hw/rtl/olir_cell.sv @@
`timescale 1ns / 1ps

module olir_cell (
   input  logic                              clock,
   input  olir_pkg::cell_cmd_type            cmd,
   input  logic [olir_pkg::IDX_W-1:0]        my_index,
   input  logic signed [olir_pkg::VAL_W-1:0] lower_slot,
   input  logic signed [olir_pkg::VAL_W-1:0] upper_slot,
   output logic signed [olir_pkg::VAL_W-1:0] slot
);

   logic signed [olir_pkg::VAL_W-1:0] slot_ff;
   logic signed [olir_pkg::VAL_W-1:0] slot_in;

   // load, shift up, shift down or hold
   always_comb begin
      slot_in = slot_ff;
      if (cmd.insert) begin
         if (my_index == cmd.at) begin
            slot_in = cmd.value;
         end else if (my_index > cmd.at) begin
            slot_in = lower_slot;
         end
      end else if (cmd.remove && (my_index >= cmd.at)) begin
         slot_in = upper_slot;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot = slot_ff;

endmodule

@@ hw/rtl/ordered_list_insert_remove_core.sv @@
// ordered list of up to 16 signed 32-bit entries held in a row of slot cells
// the response beat is registered and valid in the cycle after its request beat is accepted
// throughput: 1 beat per cycle while responses are taken; all cells shift, load or hold in the same cycle
// the response register frees when its beat is taken, so a new request can be accepted in that same cycle
// reset: synchronous, clears the entry count and the response valid; slots are not cleared
`timescale 1ns / 1ps

`include "ordered_list_insert_remove_core_macros.svh"

module ordered_list_insert_remove_core (
   input logic        clock,
   input logic        reset,
   olir_req_if.sink   req_chan,
   olir_rsp_if.source rsp_chan
);

   logic                              accept;
   logic [olir_pkg::CNT_W-1:0]        count_ff;
   logic [olir_pkg::CNT_W-1:0]        count_in;
   logic [olir_pkg::CNT_W-1:0]        cap_count;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [olir_pkg::VAL_W-1:0] rsp_popped_ff;
   logic [olir_pkg::ST_W-1:0]         rsp_status_ff;
   logic [olir_pkg::CNT_W-1:0]        rsp_count_ff;
   logic [olir_pkg::ST_W-1:0]         status;
   logic                              refused;
   logic signed [olir_pkg::VAL_W-1:0] popped;
   logic                              do_insert;
   logic                              do_remove;
   logic [olir_pkg::IDX_W-1:0]        at;
   logic                              is_full;
   logic                              is_empty;
   olir_pkg::cell_cmd_type            cmd;
   logic signed [olir_pkg::VAL_W-1:0] slot_bus [olir_pkg::CAPACITY];

   // output register frees when taken
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign cap_count = olir_pkg::CNT_W'(olir_pkg::CAPACITY);
   assign is_full   = (count_ff == cap_count);
   assign is_empty  = (count_ff == '0);

   // decode the operation and check it against the count
   always_comb begin
      status    = olir_pkg::ST_OK;
      popped    = '0;
      do_insert = 1'b0;
      do_remove = 1'b0;
      at        = req_chan.position[olir_pkg::IDX_W-1:0];
      case (req_chan.op)
         olir_pkg::OP_APPEND: begin
            at = count_ff[olir_pkg::IDX_W-1:0];
            if (is_full) begin
               status = olir_pkg::ST_FULL;
            end else begin
               do_insert = 1'b1;
            end
         end
         olir_pkg::OP_INSERT: begin
            if (is_full) begin
               status = olir_pkg::ST_FULL;
            end else if (req_chan.position > count_ff) begin
               status = olir_pkg::ST_RANGE;
            end else begin
               do_insert = 1'b1;
            end
         end
         olir_pkg::OP_POP: begin
            at = '0;
            if (is_empty) begin
               status = olir_pkg::ST_EMPTY;
            end else begin
               do_remove = 1'b1;
               popped    = slot_bus[0];
            end
         end
         olir_pkg::OP_REMOVE: begin
            if (is_empty) begin
               status = olir_pkg::ST_EMPTY;
            end else if (req_chan.position >= count_ff) begin
               status = olir_pkg::ST_RANGE;
            end else begin
               do_remove = 1'b1;
            end
         end
         default: begin
            status = olir_pkg::ST_OK;
         end
      endcase
   end

   assign refused = accept && (status != olir_pkg::ST_OK);

   // command to the cell row, only on an accepted beat
   always_comb begin
      cmd.insert = accept && do_insert;
      cmd.remove = accept && do_remove;
      cmd.at     = at;
      cmd.value  = req_chan.value;
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + olir_pkg::CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - olir_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // row of slot cells, each fed by its neighbors
   for (genvar i = 0; i < olir_pkg::CAPACITY; i++) begin : g_cell
      logic signed [olir_pkg::VAL_W-1:0] lower;
      logic signed [olir_pkg::VAL_W-1:0] upper;

      if (i == 0) begin : g_first
         assign lower = '0;
      end else begin : g_inner_lo
         assign lower = slot_bus[i-1];
      end

      if (i == olir_pkg::CAPACITY - 1) begin : g_last
         assign upper = '0;
      end else begin : g_inner_hi
         assign upper = slot_bus[i+1];
      end

      olir_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .my_index   (olir_pkg::IDX_W'(i)),
         .lower_slot (lower),
         .upper_slot (upper),
         .slot       (slot_bus[i])
      );
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_popped_ff <= popped;
         rsp_status_ff <= status;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.popped_value = rsp_popped_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.count        = rsp_count_ff;

   // checks
   `OLIR_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= cap_count)
   `OLIR_ASSERT_NEXT(a_count_idle, clock, reset, !accept, $stable(count_ff))
   `OLIR_ASSERT_NEXT(a_refused_holds, clock, reset, refused, $stable(count_ff))
   `OLIR_ASSERT_NEXT(a_rsp_count, clock, reset, accept, rsp_valid_ff && (rsp_count_ff == count_ff))

endmodule
